### sv/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int DATA_W       = 32;
   localparam int PRIO_W       = 16;
   localparam int CMD_W        = 2;
   localparam int COUNT_W      = 5;

   localparam logic [CMD_W-1:0] OP_ENQ  = 2'd0;
   localparam logic [CMD_W-1:0] OP_DEQ  = 2'd1;
   localparam logic [CMD_W-1:0] OP_PEEK = 2'd2;

   typedef struct packed {
      logic             exec;
      logic [CMD_W-1:0] op;
   } dp_cmd_type;

endpackage

`default_nettype wire

### sv/spq_control.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_control (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [spq_pkg::CMD_W-1:0] req_cmd,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output spq_pkg::dp_cmd_type     dp_cmd
);
   import spq_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_RESULT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready = !reset && ((state_ff == ST_IDLE) || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_RESULT);

   assign dp_cmd.exec = accept;
   assign dp_cmd.op   = req_cmd;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (rsp_ready && !accept) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### sv/spq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_datapath #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire spq_pkg::dp_cmd_type                dp_cmd,
   input  wire logic signed [spq_pkg::DATA_W-1:0]  in_data,
   input  wire logic signed [spq_pkg::PRIO_W-1:0]  in_priority,
   output logic                                    rsp_ok,
   output logic signed [spq_pkg::DATA_W-1:0]       rsp_head_data,
   output logic signed [spq_pkg::PRIO_W-1:0]       rsp_head_priority,
   output logic [spq_pkg::COUNT_W-1:0]             rsp_entry_count,
   output logic                                    rsp_is_empty,
   output logic                                    rsp_is_full
);
   import spq_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   logic signed [DATA_W-1:0] slot_data_ff [CAPACITY];
   logic signed [PRIO_W-1:0] slot_prio_ff [CAPACITY];
   logic signed [DATA_W-1:0] slot_data_in [CAPACITY];
   logic signed [PRIO_W-1:0] slot_prio_in [CAPACITY];
   logic signed [DATA_W-1:0] prev_data    [CAPACITY];
   logic signed [PRIO_W-1:0] prev_prio    [CAPACITY];
   logic signed [DATA_W-1:0] next_data    [CAPACITY];
   logic signed [PRIO_W-1:0] next_prio    [CAPACITY];
   logic [CAPACITY-1:0]      lt;
   logic [CAPACITY-1:0]      lt_prev;

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          empty;
   logic          full;
   logic          op_ok;
   logic          do_enq;
   logic          do_deq;

   logic                     ok_ff;
   logic signed [DATA_W-1:0] head_data_ff;
   logic signed [PRIO_W-1:0] head_prio_ff;
   logic [CW-1:0]            out_count_ff;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CW'(CAPACITY));

   always_comb begin
      op_ok = 1'b0;
      case (dp_cmd.op)
         OP_ENQ:  op_ok = !full;
         OP_DEQ:  op_ok = !empty;
         OP_PEEK: op_ok = !empty;
         default: op_ok = 1'b0;
      endcase
   end

   assign do_enq = dp_cmd.exec && op_ok && (dp_cmd.op == OP_ENQ);
   assign do_deq = dp_cmd.exec && op_ok && (dp_cmd.op == OP_DEQ);

   for (genvar k = 0; k < CAPACITY; k++) begin : g_slot
      assign lt[k] = (CW'(k) < count_ff) && (slot_prio_ff[k] < in_priority);
      if (k == 0) begin : g_first
         assign prev_data[k] = in_data;
         assign prev_prio[k] = in_priority;
         assign lt_prev[k]   = 1'b0;
      end else begin : g_inner
         assign prev_data[k] = slot_data_ff[k-1];
         assign prev_prio[k] = slot_prio_ff[k-1];
         assign lt_prev[k]   = lt[k-1];
      end
      if (k == CAPACITY - 1) begin : g_last
         assign next_data[k] = slot_data_ff[k];
         assign next_prio[k] = slot_prio_ff[k];
      end else begin : g_below
         assign next_data[k] = slot_data_ff[k+1];
         assign next_prio[k] = slot_prio_ff[k+1];
      end
   end

   always_comb begin
      for (int k = 0; k < CAPACITY; k++) begin
         slot_data_in[k] = slot_data_ff[k];
         slot_prio_in[k] = slot_prio_ff[k];
         if (do_enq) begin
            if (lt_prev[k]) begin
               slot_data_in[k] = prev_data[k];
               slot_prio_in[k] = prev_prio[k];
            end else if (lt[k] || (CW'(k) == count_ff)) begin
               slot_data_in[k] = in_data;
               slot_prio_in[k] = in_priority;
            end
         end else if (do_deq) begin
            slot_data_in[k] = next_data[k];
            slot_prio_in[k] = next_prio[k];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_enq) begin
         count_in = count_ff + CW'(1);
      end else if (do_deq) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < CAPACITY; k++) begin
         slot_data_ff[k] <= slot_data_in[k];
         slot_prio_ff[k] <= slot_prio_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.exec) begin
         ok_ff        <= op_ok;
         out_count_ff <= count_in;
         if (op_ok && (dp_cmd.op != OP_ENQ)) begin
            head_data_ff <= slot_data_ff[0];
            head_prio_ff <= slot_prio_ff[0];
         end else begin
            head_data_ff <= '0;
            head_prio_ff <= '0;
         end
      end
   end

   logic [CW+COUNT_W-1:0] count_ext;

   assign count_ext         = {{COUNT_W{1'b0}}, out_count_ff};
   assign rsp_ok            = ok_ff;
   assign rsp_head_data     = head_data_ff;
   assign rsp_head_priority = head_prio_ff;
   assign rsp_entry_count   = count_ext[COUNT_W-1:0];
   assign rsp_is_empty      = (out_count_ff == '0);
   assign rsp_is_full       = (out_count_ff == CW'(CAPACITY));

endmodule

`default_nettype wire

### sv/sorted_priority_queue_unit.sv
// Bounded priority queue of CAPACITY entries kept sorted by descending signed
// priority; equal priorities leave in arrival order. Each request (enqueue,
// dequeue, peek; other codes are refused) yields one response with success,
// head pair, entry count and empty/full flags. Every slot compares its
// priority with the incoming one and shifts in parallel, so one request is
// accepted per cycle while each response is taken when offered, and the
// response register lets the next request enter while the previous response
// is still being taken. entry_count shows the count modulo 32.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue_unit #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [spq_pkg::CMD_W-1:0]         req_cmd,
   input  wire logic signed [spq_pkg::DATA_W-1:0] req_in_data,
   input  wire logic signed [spq_pkg::PRIO_W-1:0] req_in_priority,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_ok,
   output logic signed [spq_pkg::DATA_W-1:0]      rsp_head_data,
   output logic signed [spq_pkg::PRIO_W-1:0]      rsp_head_priority,
   output logic [spq_pkg::COUNT_W-1:0]            rsp_entry_count,
   output logic                                   rsp_is_empty,
   output logic                                   rsp_is_full
);
   import spq_pkg::*;

   dp_cmd_type dp_cmd;

   spq_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_cmd    (dp_cmd)
   );

   spq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .dp_cmd            (dp_cmd),
      .in_data           (req_in_data),
      .in_priority       (req_in_priority),
      .rsp_ok            (rsp_ok),
      .rsp_head_data     (rsp_head_data),
      .rsp_head_priority (rsp_head_priority),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_is_empty      (rsp_is_empty),
      .rsp_is_full       (rsp_is_full)
   );

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted request produced no response");

   a_refused_head_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_head_data == '0 && rsp_head_priority == '0))
      else $error("refused response carries a head value");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_empty && rsp_is_full))
      else $error("response both empty and full");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_empty) |-> (rsp_entry_count == '0))
      else $error("empty response with nonzero count");

endmodule

`default_nettype wire

### tb/sorted_priority_queue_unit_tb.sv
`timescale 1ns / 1ps

module sorted_priority_queue_unit_tb;

   import spq_pkg::*;

   localparam int QCAP = CAPACITY_DEF;
   localparam logic [CMD_W-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic                     ok;
      logic signed [DATA_W-1:0] head_data;
      logic signed [PRIO_W-1:0] head_priority;
      logic [COUNT_W-1:0]       entry_count;
      logic                     is_empty;
      logic                     is_full;
   } queue_response_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [CMD_W-1:0]         req_cmd = OP_PEEK;
   logic signed [DATA_W-1:0] req_in_data = '0;
   logic signed [PRIO_W-1:0] req_in_priority = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_ok;
   logic signed [DATA_W-1:0] rsp_head_data;
   logic signed [PRIO_W-1:0] rsp_head_priority;
   logic [COUNT_W-1:0]       rsp_entry_count;
   logic                     rsp_is_empty;
   logic                     rsp_is_full;

   logic signed [DATA_W-1:0] shadow_data [QCAP];
   logic signed [PRIO_W-1:0] shadow_prio [QCAP];
   int                       shadow_count = 0;

   queue_response_type awaited_responses[$];
   int                 fail_count = 0;
   bit                 send_idle = 1'b1;
   bit                 drain_idle = 1'b1;

   sorted_priority_queue_unit #(
      .CAPACITY(QCAP)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_in_data(req_in_data),
      .req_in_priority(req_in_priority),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_ok(rsp_ok),
      .rsp_head_data(rsp_head_data),
      .rsp_head_priority(rsp_head_priority),
      .rsp_entry_count(rsp_entry_count),
      .rsp_is_empty(rsp_is_empty),
      .rsp_is_full(rsp_is_full)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic queue_response_type apply_queue_cmd(
         input logic [CMD_W-1:0] cmd,
         input logic signed [DATA_W-1:0] data,
         input logic signed [PRIO_W-1:0] prio);
      queue_response_type r;
      int pos;
      r.ok = 1'b0;
      r.head_data = '0;
      r.head_priority = '0;
      if (cmd == OP_ENQ) begin
         if (shadow_count < QCAP) begin
            pos = shadow_count;
            while (pos > 0 && shadow_prio[pos-1] < prio) begin
               shadow_data[pos] = shadow_data[pos-1];
               shadow_prio[pos] = shadow_prio[pos-1];
               pos--;
            end
            shadow_data[pos] = data;
            shadow_prio[pos] = prio;
            shadow_count++;
            r.ok = 1'b1;
         end
      end else if (cmd == OP_DEQ || cmd == OP_PEEK) begin
         if (shadow_count > 0) begin
            r.ok = 1'b1;
            r.head_data = shadow_data[0];
            r.head_priority = shadow_prio[0];
            if (cmd == OP_DEQ) begin
               for (int k = 1; k < shadow_count; k++) begin
                  shadow_data[k-1] = shadow_data[k];
                  shadow_prio[k-1] = shadow_prio[k];
               end
               shadow_count--;
            end
         end
      end
      r.entry_count = shadow_count[COUNT_W-1:0];
      r.is_empty = (shadow_count == 0);
      r.is_full = (shadow_count == QCAP);
      return r;
   endfunction

   function automatic int draw_wait(input bit enabled);
      return enabled ? $urandom_range(0, 11) : 0;
   endfunction

   task automatic send_request(input logic [CMD_W-1:0] cmd,
                               input logic signed [DATA_W-1:0] data,
                               input logic signed [PRIO_W-1:0] prio);
      int gap;
      gap = draw_wait(send_idle);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_in_data <= data;
      req_in_priority <= prio;
      do @(posedge clock); while (!req_ready);
      awaited_responses.push_back(apply_queue_cmd(cmd, data, prio));
   endtask

   task automatic test_empty_refusals();
      send_request(OP_DEQ, 32'sd5, 16'sd5);
      send_request(OP_PEEK, 32'sd7, -16'sd7);
      send_request(OP_UNUSED, -32'sd1, -16'sd1);
   endtask

   task automatic test_fill_and_order();
      logic signed [DATA_W-1:0] data;
      logic signed [PRIO_W-1:0] prio;
      for (int i = 0; i < QCAP; i++) begin
         case (i)
            0: data = 32'sh7fffffff;
            1: data = 32'sh80000000;
            2: data = '0;
            3: data = -32'sd1;
            default: data = $urandom;
         endcase
         case (i)
            0: prio = 16'sh7fff;
            1: prio = 16'sh8000;
            2: prio = 16'sh7fff;
            3: prio = 16'sh8000;
            default: prio = PRIO_W'((i % 3) - 1);
         endcase
         send_request(OP_ENQ, data, prio);
      end
   endtask

   task automatic test_full_refusals();
      send_request(OP_ENQ, 32'sh12345678, 16'sh7fff);
      send_request(OP_UNUSED, 32'sh7fffffff, 16'sh7fff);
      send_request(OP_PEEK, '0, '0);
      send_request(OP_DEQ, '0, '0);
   endtask

   task automatic test_random_traffic(input int n_items);
      bit                       grow;
      int                       r;
      logic [CMD_W-1:0]         cmd;
      logic signed [DATA_W-1:0] data;
      logic signed [PRIO_W-1:0] prio;
      grow = 1'b1;
      for (int i = 0; i < n_items; i++) begin
         if (i % 100 == 0) begin
            send_idle = ($urandom_range(0, 3) != 0);
            drain_idle = ($urandom_range(0, 3) != 0);
         end
         if (shadow_count == QCAP) grow = 1'b0;
         else if (shadow_count == 0) grow = 1'b1;
         else if ($urandom_range(0, 39) == 0) grow = !grow;
         r = $urandom_range(0, 99);
         if (r < 3) cmd = OP_UNUSED;
         else if (r < 13) cmd = OP_PEEK;
         else if ((r < 68) == grow) cmd = OP_ENQ;
         else cmd = OP_DEQ;
         case ($urandom_range(0, 7))
            0: data = 32'sh7fffffff;
            1: data = 32'sh80000000;
            default: data = $urandom;
         endcase
         case ($urandom_range(0, 3))
            0: prio = PRIO_W'($urandom_range(0, 65535));
            1: prio = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: prio = PRIO_W'(int'($urandom_range(0, 6)) - 3);
         endcase
         send_request(cmd, data, prio);
      end
   endtask

   initial begin
      wait (!reset);
      forever begin
         int stall;
         stall = draw_wait(drain_idle);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      queue_response_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_responses.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("response with none outstanding: ok=%0b data=%0d prio=%0d count=%0d",
                        rsp_ok, rsp_head_data, rsp_head_priority, rsp_entry_count);
         end else begin
            want = awaited_responses.pop_front();
            if (rsp_ok !== want.ok || rsp_head_data !== want.head_data ||
                rsp_head_priority !== want.head_priority ||
                rsp_entry_count !== want.entry_count ||
                rsp_is_empty !== want.is_empty || rsp_is_full !== want.is_full) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("mismatch at %0t: expected ok=%0b data=%0d prio=%0d",
                           $realtime, want.ok, want.head_data, want.head_priority);
                  $display("   expected count=%0d empty=%0b full=%0b",
                           want.entry_count, want.is_empty, want.is_full);
                  $display("   actual ok=%0b data=%0d prio=%0d",
                           rsp_ok, rsp_head_data, rsp_head_priority);
                  $display("   actual count=%0d empty=%0b full=%0b",
                           rsp_entry_count, rsp_is_empty, rsp_is_full);
               end
            end
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_empty_refusals();
      test_fill_and_order();
      test_full_refusals();
      test_random_traffic(1300);
      req_valid <= 1'b0;
      while (awaited_responses.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && awaited_responses.size() == 0) begin
         $display("** sorted_priority_queue_unit: PASSED **");
      end else begin
         $display("** sorted_priority_queue_unit: FAILED **");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("** sorted_priority_queue_unit: FAILED **");
      $finish;
   end

endmodule
